>>> design/lstf_pkg.sv
// Shared constants for the local standard deviation texture filter.
`timescale 1ns / 1ps
`default_nettype none
package lstf_pkg;
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxWindowDef = 15;
  localparam int unsigned PixelBitsDef = 8;
  localparam int unsigned PixW         = 8;
  localparam int unsigned RowW         = 16;
  localparam int unsigned ColW         = 11;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;
  localparam logic [CfgIdxW-1:0] RegRowWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRowCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindow    = 2'd2;
  localparam logic [11:0] RowWidthRst = 12'd2048;
  localparam logic [15:0] RowCountRst = 16'd512;
  localparam logic [3:0]  WindowRst   = 4'd3;
endpackage
`default_nettype wire

>>> design/lstf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lstf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/local_stdev_texture_filter.sv
// Local standard deviation texture filter: top level with sequencer and shared datapath.
`timescale 1ns / 1ps
`default_nettype none
// One pixel is taken per transaction and the block then stays busy. It first finds the
// line store row slot of the pixel's row as a 16-step serial remainder of the row by
// W-1. It then reads the W-1 stored samples of the pixel's column from the line store,
// one per cycle. For an interior pixel it then sums the W column sums, forms N*Q and
// S*S, works the divide one quotient bit a cycle and the square root one result bit a
// cycle. The remainder, the serial divider and the square root take most of an
// interior pixel's busy time. A result waits in an output register, and the next
// pixel is taken while it waits. Line store entries never written read as garbage.
module local_stdev_texture_filter #(
  parameter int unsigned MAX_WIDTH  = lstf_pkg::MaxWidthDef,
  parameter int unsigned MAX_WINDOW = lstf_pkg::MaxWindowDef,
  parameter int unsigned PIXEL_BITS = lstf_pkg::PixelBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lstf_pkg::PixW-1:0]     pixel_i,
  input  wire logic                          frame_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [lstf_pkg::PixW-1:0]     texture_o,
  output logic      [lstf_pkg::RowW-1:0]     out_row_o,
  output logic      [lstf_pkg::ColW-1:0]     out_col_o,
  output logic                               frame_last_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lstf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lstf_pkg::CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned PB    = (PIXEL_BITS > 8) ? 8 : PIXEL_BITS;
  localparam int unsigned SRows = MAX_WINDOW - 1;
  localparam int unsigned SlotW = $clog2(SRows);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned Depth = SRows * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned WinW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned NW    = 2 * WinW;
  // Column sum widths: up to MAX_WINDOW samples.
  localparam int unsigned CsW   = PB + WinW;
  localparam int unsigned CqW   = 2 * PB + WinW;
  localparam int unsigned SW    = CsW + WinW;
  localparam int unsigned QW    = CqW + WinW;
  localparam int unsigned NumW  = QW + NW;
  localparam int unsigned DenW  = 2 * NW;
  localparam int unsigned RootW = (NumW + 1) / 2;
  localparam int unsigned DivCW = $clog2(NumW + 1);
  localparam logic [PB-1:0] MaxV = '1;

  typedef enum logic [3:0] {
    StIdle, StMod, StRead, StAcc, StSum, StMulQ, StMulS, StDiff, StDiv, StSqrt, StOut
  } state_e;

  // Configuration registers.
  logic [11:0] row_width_q;
  logic [15:0] row_count_q;
  logic [3:0]  window_q;

  // Effective geometry.
  logic [WinW-1:0] cap_w, w_eff, wm1;
  logic [CW:0]     width_eff;
  logic [15:0]     rows_eff;
  always_comb begin
    logic [WinW-1:0] t;
    cap_w = WinW'((MAX_WINDOW - 1) | 1);
    if (cap_w > WinW'(MAX_WINDOW)) cap_w = cap_w - WinW'(2);
    t = (window_q < 4'd3) ? WinW'(3) : WinW'(window_q);
    t = (t - WinW'(1)) | WinW'(1);
    w_eff = (t > cap_w) ? cap_w : t;
    wm1   = w_eff - WinW'(1);
    if (row_width_q < 12'd3) width_eff = (CW+1)'(3);
    else if (32'(row_width_q) > MAX_WIDTH) width_eff = (CW+1)'(MAX_WIDTH);
    else width_eff = (CW+1)'(row_width_q);
    rows_eff = (row_count_q < 16'd3) ? 16'd3 : row_count_q;
  end

  state_e             state_q;
  logic [CW-1:0]      col_q;
  logic [15:0]        row_q;
  logic [CW-1:0]      c_q;
  logic [15:0]        r_q;
  logic [SlotW-1:0]   slot_q, base_slot_q;
  logic [15:0]        mod_src_q;
  logic [WinW-1:0]    mod_q;
  logic [WinW-1:0]    cnt_q;
  logic [PB-1:0]      pix_q;
  logic [CsW-1:0]     s_acc_q;
  logic [CqW-1:0]     q_acc_q;
  logic [CsW-1:0]     csum_q [MAX_WINDOW];
  logic [CqW-1:0]     csq_q  [MAX_WINDOW];
  logic [SW-1:0]      ws_q;
  logic [QW-1:0]      wq_q;
  logic [NumW-1:0]    nq_q, ss_q, num_q;
  logic [DenW-1:0]    den_q;
  logic [NumW-1:0]    quo_q, rem_q;
  logic [DivCW-1:0]   dcnt_q;
  logic [NumW-1:0]    rv_q;
  logic [RootW-1:0]   res_q;
  logic [NumW-1:0]    bit_q;
  logic               read_ok_q;
  logic               out_valid_q;
  logic [PB-1:0]      tex_q;
  logic [15:0]        orow_q;
  logic [CW-1:0]      ocol_q;
  logic               olast_q;

  // Line store.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PB-1:0] ram_rdata;
  assign ram_we    = (state_q == StAcc) && (cnt_q == wm1 - WinW'(1));
  assign ram_waddr = AW'(32'(base_slot_q) * MAX_WIDTH + 32'(c_q));
  assign ram_raddr = AW'(32'(slot_q) * MAX_WIDTH + 32'(c_q));
  lstf_ram #(.Width(PB), .Depth(Depth)) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (pix_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_acc;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !out_valid_q;

  // Output register load and drain conditions.
  logic out_take, out_load;
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = (state_q == StOut) && (!out_valid_q || !out_stall_i) && read_ok_q;

  // Helper values of the datapath.
  logic [CW-1:0] c_in;
  logic [15:0]   r_in;
  logic [SlotW-1:0] slot_inc;
  logic [NumW-1:0]  trial;
  logic [NumW:0]    rem_sh;
  logic [WinW:0]    mod_sh, mod_nxt;
  always_comb begin
    c_in = frame_start_i ? '0 : col_q;
    r_in = frame_start_i ? '0 : row_q;
    slot_inc = (slot_q == SlotW'(wm1 - WinW'(1))) ? '0 : slot_q + SlotW'(1);
    trial  = rv_q - (NumW'(res_q) + bit_q);
    rem_sh = {rem_q, num_q[NumW-1]};
    mod_sh  = {mod_q, mod_src_q[15]};
    mod_nxt = (mod_sh >= {1'b0, wm1}) ? mod_sh - {1'b0, wm1} : mod_sh;
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      row_width_q <= lstf_pkg::RowWidthRst;
      row_count_q <= lstf_pkg::RowCountRst;
      window_q    <= lstf_pkg::WindowRst;
      for (int k = 0; k < MAX_WINDOW; k++) begin
        csum_q[k] <= '0;
        csq_q[k]  <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          lstf_pkg::RegRowWidth: row_width_q <= cfg_data_i[11:0];
          lstf_pkg::RegRowCount: row_count_q <= cfg_data_i;
          lstf_pkg::RegWindow:   window_q    <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            c_q       <= c_in;
            r_q       <= r_in;
            pix_q     <= pixel_i[PB-1:0];
            s_acc_q   <= CsW'(pixel_i[PB-1:0]);
            q_acc_q   <= CqW'(pixel_i[PB-1:0] * pixel_i[PB-1:0]);
            mod_src_q <= r_in;
            mod_q     <= '0;
            dcnt_q    <= '0;
            cnt_q     <= '0;
            state_q   <= StMod;
          end
        end
        StMod: begin
          // Row slot as the remainder of the row by W-1, one row bit a cycle.
          mod_q     <= WinW'(mod_nxt);
          mod_src_q <= {mod_src_q[14:0], 1'b0};
          dcnt_q    <= dcnt_q + DivCW'(1);
          if (dcnt_q == DivCW'(15)) begin
            slot_q      <= SlotW'(mod_nxt);
            base_slot_q <= SlotW'(mod_nxt);
            state_q     <= StRead;
          end
        end
        StRead: begin
          slot_q  <= slot_inc;
          state_q <= StAcc;
        end
        StAcc: begin
          s_acc_q <= s_acc_q + CsW'(ram_rdata);
          q_acc_q <= q_acc_q + CqW'(ram_rdata * ram_rdata);
          cnt_q   <= cnt_q + WinW'(1);
          if (cnt_q == wm1 - WinW'(1)) begin
            state_q <= StSum;
          end else begin
            slot_q  <= slot_inc;
          end
        end
        StSum: begin
          for (int k = MAX_WINDOW - 1; k > 0; k--) begin
            csum_q[k] <= csum_q[k-1];
            csq_q[k]  <= csq_q[k-1];
          end
          csum_q[0] <= s_acc_q;
          csq_q[0]  <= q_acc_q;
          ws_q  <= '0;
          wq_q  <= '0;
          cnt_q <= '0;
          if (r_q >= 16'(wm1) && c_q >= CW'(wm1)) begin
            read_ok_q <= 1'b1;
            state_q   <= StMulQ;
          end else begin
            read_ok_q <= 1'b0;
            state_q   <= StOut;
          end
        end
        StMulQ: begin
          // Serial window sum over the column sums, one column a cycle.
          if (cnt_q == w_eff) begin
            nq_q    <= NumW'(wq_q) * NumW'(w_eff * w_eff);
            den_q   <= DenW'(w_eff * w_eff) * DenW'(w_eff * w_eff - WinW'(1));
            state_q <= StMulS;
          end else begin
            ws_q  <= ws_q + SW'(csum_q[cnt_q]);
            wq_q  <= wq_q + QW'(csq_q[cnt_q]);
            cnt_q <= cnt_q + WinW'(1);
          end
        end
        StMulS: begin
          ss_q    <= NumW'(ws_q) * NumW'(ws_q);
          state_q <= StDiff;
        end
        StDiff: begin
          num_q   <= (nq_q >= ss_q) ? nq_q - ss_q : '0;
          rem_q   <= '0;
          quo_q   <= '0;
          dcnt_q  <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          // Restoring division, one quotient bit a cycle.
          if (rem_sh >= (NumW+1)'(den_q)) begin
            rem_q <= NumW'(rem_sh - (NumW+1)'(den_q));
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= NumW'(rem_sh);
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          num_q  <= num_q << 1;
          dcnt_q <= dcnt_q + DivCW'(1);
          if (dcnt_q == DivCW'(NumW - 1)) begin
            state_q <= StSqrt;
            res_q   <= '0;
            bit_q   <= NumW'(1) << (2 * (RootW - 1));
          end
        end
        StSqrt: begin
          // Digit-by-digit square root, two radicand bits a cycle.
          if (bit_q == NumW'(1) << (2 * (RootW - 1)) && res_q == '0 && dcnt_q != '0) begin
            rv_q   <= quo_q;
            dcnt_q <= '0;
          end else if (bit_q == '0) begin
            state_q <= StOut;
          end else begin
            if (rv_q >= NumW'(res_q) + bit_q) begin
              rv_q  <= trial;
              res_q <= RootW'((NumW'(res_q) >> 1) + bit_q);
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            if (read_ok_q) begin
              tex_q  <= (res_q > RootW'(MaxV)) ? MaxV : PB'(res_q);
              orow_q <= r_q - 16'(w_eff >> 1);
              ocol_q <= c_q - CW'(w_eff >> 1);
              olast_q <= (r_q == rows_eff - 16'd1) && ((CW+1)'(c_q) == width_eff - 1'b1);
            end
            if ((CW+1)'(c_q) + 1'b1 >= width_eff) begin
              col_q <= '0;
              row_q <= (r_q + 16'd1 >= rows_eff) ? 16'd0 : r_q + 16'd1;
            end else begin
              col_q <= c_q + CW'(1);
              row_q <= r_q;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign texture_o    = lstf_pkg::PixW'(tex_q);
  assign out_row_o    = orow_q;
  assign out_col_o    = lstf_pkg::ColW'(ocol_q);
  assign frame_last_o = olast_q;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(texture_o)))
    else $error("stalled result changed");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StMod)) else $error("accepted pixel not started");
`endif
endmodule
`default_nettype wire

>>> verif/lstf_checker.sv
// Prediction and checking of the texture filter's result stream.
`timescale 1ns / 1ps
`default_nettype none
module lstf_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic [lstf_pkg::PixW-1:0]     pixel_i,
  input  wire logic                          frame_start_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [lstf_pkg::PixW-1:0]     texture_i,
  input  wire logic [lstf_pkg::RowW-1:0]     out_row_i,
  input  wire logic [lstf_pkg::ColW-1:0]     out_col_i,
  input  wire logic                          frame_last_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_i,
  input  wire logic [lstf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lstf_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);
  localparam int unsigned PixW         = lstf_pkg::PixW;
  localparam int unsigned RowW         = lstf_pkg::RowW;
  localparam int unsigned ColW         = lstf_pkg::ColW;
  localparam int unsigned MaxWindowDef = lstf_pkg::MaxWindowDef;
  localparam int unsigned MaxWidthDef  = lstf_pkg::MaxWidthDef;
  localparam int unsigned StoreRows    = MaxWindowDef - 1;

  typedef struct packed {
    logic [PixW-1:0] texture;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } texture_res_t;

  texture_res_t texture_expect_q[$];

  // Shadow copy of the filter state and its registers.
  logic [PixW-1:0]   line_mem [StoreRows*MaxWidthDef];
  longint unsigned   colsum_sr [MaxWindowDef];
  longint unsigned   colsq_sr [MaxWindowDef];
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic [11:0]       width_reg;
  logic [15:0]       rows_reg;
  logic [3:0]        window_reg;

  assign pending_o = $unsigned(texture_expect_q.size());

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Advances the shadow state by one pixel and queues the texture it yields.
  task automatic predict_texture(input logic [PixW-1:0] pix, input logic fs);
    int unsigned     win, wm1, wid, nrows, c, r, slot;
    longint unsigned s, q, v, wsum, wsq, n, num, res;
    texture_res_t    exp_res;
    win = (window_reg < 3) ? 3 : window_reg;
    win = (win - 1) | 1;
    if (win > MaxWindowDef) win = MaxWindowDef;
    wm1 = win - 1;
    wid = width_reg;
    if (wid < 3) wid = 3;
    if (wid > MaxWidthDef) wid = MaxWidthDef;
    nrows = (rows_reg < 3) ? 3 : rows_reg;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = (col_pos >= MaxWidthDef) ? MaxWidthDef - 1 : col_pos;
    r = row_pos;
    s = pix;
    q = pix * pix;
    for (int i = 0; i < wm1; i++) begin
      slot = (r + i) % wm1;
      v = line_mem[slot*MaxWidthDef + c];
      s += v;
      q += v * v;
    end
    line_mem[(r % wm1)*MaxWidthDef + c] = pix;
    for (int k = MaxWindowDef - 1; k > 0; k--) begin
      colsum_sr[k] = colsum_sr[k-1];
      colsq_sr[k] = colsq_sr[k-1];
    end
    colsum_sr[0] = s;
    colsq_sr[0] = q;
    // Interior pixel: the window's bottom-right corner has arrived.
    if (r >= wm1 && c >= wm1) begin
      wsum = 0;
      wsq = 0;
      n = win * win;
      for (int k = 0; k < win; k++) begin
        wsum += colsum_sr[k];
        wsq += colsq_sr[k];
      end
      num = n * wsq;
      num = (num >= wsum * wsum) ? num - wsum * wsum : 0;
      res = int_sqrt(num / (n * (n - 1)));
      if (res > 255) res = 255;
      exp_res.texture = res[PixW-1:0];
      exp_res.row = RowW'(r - win/2);
      exp_res.col = ColW'(c - win/2);
      exp_res.last = (r == nrows - 1 && c == wid - 1);
      texture_expect_q.push_back(exp_res);
    end
    c++;
    if (c >= wid) begin
      c = 0;
      r++;
      if (r >= nrows) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Watch all three channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    texture_res_t got, exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < StoreRows*MaxWidthDef; i++) line_mem[i] = '0;
      for (int k = 0; k < MaxWindowDef; k++) begin
        colsum_sr[k] = 0;
        colsq_sr[k] = 0;
      end
      col_pos = 0;
      row_pos = 0;
      width_reg = lstf_pkg::RowWidthRst;
      rows_reg = lstf_pkg::RowCountRst;
      window_reg = lstf_pkg::WindowRst;
      fail_count_o <= 0;
      texture_expect_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lstf_pkg::RegRowWidth: width_reg = cfg_data_i[11:0];
          lstf_pkg::RegRowCount: rows_reg = cfg_data_i;
          lstf_pkg::RegWindow: window_reg = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_texture(pixel_i, frame_start_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{texture_i, out_row_i, out_col_i, frame_last_i};
        if (texture_expect_q.size() == 0) begin
          $display("%0t: unexpected result texture=%0d row=%0d col=%0d last=%0b",
                   $time, got.texture, got.row, got.col, got.last);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_res = texture_expect_q.pop_front();
          if (got !== exp_res) begin
            $display("%0t: mismatch expected texture=%0d row=%0d col=%0d last=%0b",
                     $time, exp_res.texture, exp_res.row, exp_res.col, exp_res.last);
            $display("%0t:          actual   texture=%0d row=%0d col=%0d last=%0b",
                     $time, got.texture, got.row, got.col, got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> verif/tb_local_stdev_texture_filter.sv
// Stimulus and verdict for the local standard deviation texture filter.
`timescale 1ns / 1ps
`default_nettype none
module tb_local_stdev_texture_filter;
  localparam int unsigned PixW     = lstf_pkg::PixW;
  localparam int unsigned RowW     = lstf_pkg::RowW;
  localparam int unsigned ColW     = lstf_pkg::ColW;
  localparam int unsigned CfgIdxW  = lstf_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = lstf_pkg::CfgDataW;

  localparam int unsigned PixelTarget = 1550;
  localparam int unsigned QuietFrom   = 1400;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned DrainCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_i = '0;
  logic                frame_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixW-1:0]     texture_o;
  logic [RowW-1:0]     out_row_o;
  logic [ColW-1:0]     out_col_o;
  logic                frame_last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         pixels_sent = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         stall_left = 0;
  bit                  quiet = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  local_stdev_texture_filter u_top (.*);

  lstf_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .pixel_i, .frame_start_i,
    .out_valid_i(out_valid_o), .out_stall_i, .texture_i(texture_o), .out_row_i(out_row_o),
    .out_col_i(out_col_o), .frame_last_i(frame_last_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side backpressure in random bursts, switched off near the end.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_pixel(input logic [PixW-1:0] pix, input logic fs);
    logic stl;
    if (!quiet && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 7)) @(negedge clk_i);
    in_valid_i = 1'b1;
    pixel_i = pix;
    frame_start_i = fs;
    forever begin
      stl = in_stall_o;
      @(posedge clk_i);
      if (!stl) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    pixels_sent++;
    quiet = (pixels_sent >= QuietFrom);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    logic rdy;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    forever begin
      rdy = cfg_ready_o;
      @(posedge clk_i);
      if (rdy) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Holds off until every expected texture is out and the datapath has drained.
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [CfgDataW-1:0] wid, input logic [CfgDataW-1:0] rows,
                              input logic [CfgDataW-1:0] win);
    settle();
    write_reg(lstf_pkg::RegRowWidth, wid);
    write_reg(lstf_pkg::RegRowCount, rows);
    write_reg(lstf_pkg::RegWindow, win);
  endtask

  // One frame in raster order; a broken frame may stop early at a random pixel.
  task automatic send_frame(input int unsigned wid, input int unsigned rows, input bit broken);
    int unsigned total, cut, style, base;
    logic [PixW-1:0] pix;
    total = wid * rows;
    cut = broken ? $urandom_range(1, total) : total;
    style = $urandom_range(0, 3);
    base = $urandom_range(0, 255);
    for (int unsigned i = 0; i < cut; i++) begin
      case (style)
        0: pix = PixW'(base);
        1: pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        2: pix = PixW'(base + $urandom_range(0, 3));
        default: pix = PixW'($urandom_range(0, 255));
      endcase
      send_pixel(pix, i == 0);
    end
  endtask

  initial begin
    int unsigned wid, rows, win;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: 5x5 frame, 3x3 window, flat, extreme and checkered areas.
    set_geometry(16'd5, 16'd5, 16'd3);
    for (int i = 0; i < 25; i++) begin
      send_pixel((i < 10) ? 8'd255 : ((i < 15) ? 8'd0 : (i[0] ? 8'd255 : 8'd0)), i == 0);
    end

    // Register extremes with short streams; of these only the 3x3 frame reaches an interior pixel.
    set_geometry(16'hFFFF, 16'hFFFF, 16'd15);
    for (int i = 0; i < 20; i++) send_pixel(PixW'($urandom_range(0, 255)), i == 0);
    set_geometry(16'd0, 16'd0, 16'd0);
    send_frame(3, 3, 1'b0);
    set_geometry(16'd4, 16'd3, 16'd5);
    send_frame(4, 3, 1'b0);
    // Largest window over its smallest frame, then an even window value.
    set_geometry(16'd15, 16'd15, 16'd15);
    send_frame(15, 15, 1'b0);
    set_geometry(16'd7, 16'd6, 16'd6);
    send_frame(7, 6, 1'b0);

    // Random geometries, mostly complete frames with some cut short.
    while (pixels_sent < PixelTarget) begin
      wid = $urandom_range(3, 14);
      rows = $urandom_range(3, 12);
      win = $urandom_range(0, 15);
      set_geometry({4'($urandom), 12'(wid)}, 16'(rows), {12'($urandom), 4'(win)});
      repeat ($urandom_range(1, 3)) begin
        if (pixels_sent < PixelTarget) send_frame(wid, rows, $urandom_range(0, 9) == 0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/lstf_pkg.sv
design/lstf_ram.sv
design/local_stdev_texture_filter.sv
verif/lstf_checker.sv
verif/tb_local_stdev_texture_filter.sv
